// ===== sv/otset_pkg.sv =====
// Shared types and event codes for the overlap set enter/exit tracker.
package otset_pkg;

  // Width of the ID fields on the ports
  localparam int unsigned ID_FIELD_W = 32;

  // Event kind codes
  localparam logic [1:0] KIND_ENTERED = 2'd0;
  localparam logic [1:0] KIND_EXITED  = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic present;     // present beat accepted this cycle
    logic clear_seen;  // end of frame with nothing to remove
  } cell_ctl_t;

  // Per-cell status back to the top level
  typedef struct packed {
    logic hit;   // stored ID matches the incoming ID
    logic emit;  // cell gives an exited event this cycle
    logic last;  // no pending exits in higher cells
  } cell_stat_t;

endpackage

// ===== sv/otset_cell.sv =====
// One slot of the tracker: stored ID, valid and seen marks, and scan token.
module otset_cell #(
  parameter int unsigned ID_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  otset_pkg::cell_ctl_t  ctl_i,
  input  logic [ID_WIDTH-1:0]   id_i,
  input  logic                  hit_any_i,
  input  logic                  free_below_i,
  output logic                  free_below_o,
  input  logic                  tok_i,
  output logic                  tok_o,
  input  logic                  pend_above_i,
  output logic                  pend_above_o,
  output otset_pkg::cell_stat_t stat_o,
  output logic [ID_WIDTH-1:0]   id_o
);

  logic                valid_q, valid_d;
  logic                seen_q, seen_d;
  logic                tok_q;
  logic [ID_WIDTH-1:0] id_q;
  logic                pend;
  logic                hit;
  logic                take;
  logic                emit;

  // Match, claim and pending terms
  assign pend = valid_q & ~seen_q;
  assign hit  = valid_q & (id_q == id_i);
  assign take = ctl_i.present & ~hit_any_i & ~free_below_i & ~valid_q;
  assign emit = tok_q & pend;

  // Hand chain terms to the neighbors
  assign free_below_o = free_below_i | ~valid_q;
  assign pend_above_o = pend_above_i | pend;
  assign tok_o        = tok_q;

  assign stat_o.hit  = hit;
  assign stat_o.emit = emit;
  assign stat_o.last = ~pend_above_i;
  assign id_o        = id_q;

  // Next state of the marks
  always_comb begin
    valid_d = valid_q;
    seen_d  = seen_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (emit) begin
      valid_d = 1'b0;
    end
    if (take || (ctl_i.present && hit)) begin
      seen_d = 1'b1;
    end else if (tok_q || ctl_i.clear_seen) begin
      seen_d = 1'b0;
    end
  end

  // Hold marks and advance the token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      seen_q  <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      seen_q  <= seen_d;
      tok_q   <= tok_i;
    end
  end

  // Store the ID on claim
  always_ff @(posedge clk_i) begin
    if (take) begin
      id_q <= id_i;
    end
  end

endmodule

// ===== sv/overlap_set_enter_exit_tracker_top.sv =====
// Top level of the overlap set enter/exit tracker: row of slot cells and event register.
// Present beat: accepted while busy is low, its event (if any) shows on the next cycle; busy stays low.
// End of frame with exits: a scan token walks the cells one per cycle, so busy is high until
//   the token leaves the last cell, and exits show in the cycle after the token reaches their cell.
// End of frame with nothing to remove: seen marks cleared at once, no event.
// Events are strobed for one cycle; the receiver cannot stall. Reset empties the set at once.
module overlap_set_enter_exit_tracker_top #(
  parameter int unsigned SET_DEPTH = 16,
  parameter int unsigned ID_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [31:0] shape_id_i,
  output logic        event_valid_o,
  output logic [1:0]  event_kind_o,
  output logic [31:0] event_id_o,
  output logic        last_of_run_o
);

  localparam int unsigned IdW = (ID_WIDTH < otset_pkg::ID_FIELD_W) ?
                                ID_WIDTH : otset_pkg::ID_FIELD_W;

  logic                  accept;
  logic [IdW-1:0]        id_in;
  otset_pkg::cell_ctl_t  ctl;
  logic                  hit_any;
  logic                  any_pend;
  logic                  full;
  logic                  eof_go;
  logic [SET_DEPTH-1:0]  free_below_in, free_below_out;
  logic [SET_DEPTH-1:0]  tok_in, tok_out;
  logic [SET_DEPTH-1:0]  pend_above_in, pend_above_out;
  logic [SET_DEPTH-1:0]  hit_vec;
  otset_pkg::cell_stat_t stat [SET_DEPTH];
  logic [IdW-1:0]        cell_id [SET_DEPTH];

  logic        ev_valid_q, ev_valid_d;
  logic [1:0]  ev_kind_q, ev_kind_d;
  logic [31:0] ev_id_q, ev_id_d;
  logic        ev_last_q, ev_last_d;

  // Accept a beat and broadcast control
  assign accept         = start & ~busy;
  assign id_in          = shape_id_i[IdW-1:0];
  assign ctl.present    = accept & ~mode_i;
  assign ctl.clear_seen = accept & mode_i & ~any_pend;
  assign eof_go         = accept & mode_i & any_pend;
  assign any_pend       = pend_above_out[0];
  assign full           = ~free_below_out[SET_DEPTH-1];
  assign hit_any        = |hit_vec;
  assign busy           = |tok_out;

  // Build the row of cells and chain them
  for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign free_below_in[g] = 1'b0;
      assign tok_in[g]        = eof_go;
    end else begin : g_rest
      assign free_below_in[g] = free_below_out[g-1];
      assign tok_in[g]        = tok_out[g-1];
    end
    if (g == SET_DEPTH - 1) begin : g_top
      assign pend_above_in[g] = 1'b0;
    end else begin : g_below
      assign pend_above_in[g] = pend_above_out[g+1];
    end
    assign hit_vec[g] = stat[g].hit;

    otset_cell #(
      .ID_WIDTH(IdW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .id_i        (id_in),
      .hit_any_i   (hit_any),
      .free_below_i(free_below_in[g]),
      .free_below_o(free_below_out[g]),
      .tok_i       (tok_in[g]),
      .tok_o       (tok_out[g]),
      .pend_above_i(pend_above_in[g]),
      .pend_above_o(pend_above_out[g]),
      .stat_o      (stat[g]),
      .id_o        (cell_id[g])
    );
  end

  // Select the next event beat
  always_comb begin
    logic [IdW-1:0] exit_id;
    logic           exit_any;
    logic           exit_last;
    exit_id   = '0;
    exit_any  = 1'b0;
    exit_last = 1'b0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      if (stat[i].emit) begin
        exit_id   = exit_id | cell_id[i];
        exit_any  = 1'b1;
        exit_last = exit_last | stat[i].last;
      end
    end
    ev_valid_d = 1'b0;
    ev_kind_d  = otset_pkg::KIND_ENTERED;
    ev_id_d    = otset_pkg::ID_FIELD_W'(id_in);
    ev_last_d  = 1'b1;
    if (ctl.present) begin
      ev_valid_d = ~hit_any;
      ev_kind_d  = full ? otset_pkg::KIND_FULL : otset_pkg::KIND_ENTERED;
    end else if (exit_any) begin
      ev_valid_d = 1'b1;
      ev_kind_d  = otset_pkg::KIND_EXITED;
      ev_id_d    = otset_pkg::ID_FIELD_W'(exit_id);
      ev_last_d  = exit_last;
    end
  end

  // Hold the event strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else begin
      ev_valid_q <= ev_valid_d;
    end
  end

  // Hold the event payload
  always_ff @(posedge clk_i) begin
    ev_kind_q <= ev_kind_d;
    ev_id_q   <= ev_id_d;
    ev_last_q <= ev_last_d;
  end

  assign event_valid_o = ev_valid_q;
  assign event_kind_o  = ev_kind_q;
  assign event_id_o    = ev_id_q;
  assign last_of_run_o = ev_last_q;

endmodule

// ===== sv/otset_checker.sv =====
// Port-level assertions for the overlap set enter/exit tracker, with its bind.
module otset_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        mode_i,
  input logic        event_valid_o,
  input logic [1:0]  event_kind_o,
  input logic        last_of_run_o
);

  // A present beat gives at most one event, never an exit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !mode_i) |=>
      (!event_valid_o || (event_kind_o != otset_pkg::KIND_EXITED)))
    else $error("present beat followed by an exit event");

  // A present beat's event closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !mode_i) |=> (!event_valid_o || last_of_run_o))
    else $error("present beat event without last_of_run");

  // Entered and full events come only right after a present beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_valid_o && (event_kind_o != otset_pkg::KIND_EXITED)) |->
      $past(start && !busy && !mode_i))
    else $error("entered or full event without a present beat");

  // Only exits show while a scan runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (!event_valid_o || (event_kind_o == otset_pkg::KIND_EXITED)))
    else $error("non-exit event during scan");

  // No undefined kind code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o |-> (event_kind_o != 2'd3))
    else $error("undefined event kind");

endmodule

bind overlap_set_enter_exit_tracker_top otset_checker u_otset_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .mode_i       (mode_i),
  .event_valid_o(event_valid_o),
  .event_kind_o (event_kind_o),
  .last_of_run_o(last_of_run_o)
);

// ===== sim/tb.sv =====
// Testbench for the overlap set enter/exit tracker: frame stimulus, set predictor, event checks.
module tb;

  localparam int unsigned SET_DEPTH = 16;
  localparam int unsigned ID_WIDTH  = 32;
  localparam logic [31:0] ID_MASK   = (ID_WIDTH >= 32) ? '1 : ((32'd1 << ID_WIDTH) - 1);
  localparam logic MODE_PRESENT   = 1'b0;
  localparam logic MODE_FRAME_END = 1'b1;
  localparam int unsigned POOL_SIZE   = 20;
  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] id;
    logic        last;
  } tracker_event_t;

  // Tracks set membership and the events each beat should cause
  class membership_board;
    logic [31:0]    slot_id   [SET_DEPTH];
    bit             slot_used [SET_DEPTH];
    bit             slot_seen [SET_DEPTH];
    tracker_event_t pending_events [$];
    int unsigned    mismatches;

    function new();
      foreach (slot_used[i]) begin
        slot_id[i]   = '0;
        slot_used[i] = 1'b0;
        slot_seen[i] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void note_beat(logic mode, logic [31:0] raw_id);
      logic [31:0]    id;
      int             free_slot;
      int unsigned    first;
      bit             hit;
      tracker_event_t ev;
      id        = raw_id & ID_MASK;
      free_slot = -1;
      hit       = 1'b0;
      first     = pending_events.size();
      if (mode == MODE_PRESENT) begin
        // Match against every stored ID, remember the lowest free slot
        for (int i = 0; i < SET_DEPTH; i++) begin
          if (!hit && slot_used[i] && slot_id[i] == id) begin
            slot_seen[i] = 1'b1;
            hit          = 1'b1;
          end
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        if (!hit) begin
          ev.id = id;
          if (free_slot >= 0) begin
            slot_id[free_slot]   = id;
            slot_used[free_slot] = 1'b1;
            slot_seen[free_slot] = 1'b1;
            ev.kind              = otset_pkg::KIND_ENTERED;
          end else begin
            ev.kind = otset_pkg::KIND_FULL;
          end
          ev.last = 1'b0;
          pending_events.insert(pending_events.size(), ev);
        end
      end else begin
        // Drop every unseen member in slot order, then clear the seen marks
        for (int i = 0; i < SET_DEPTH; i++) begin
          if (slot_used[i] && !slot_seen[i]) begin
            ev.kind = otset_pkg::KIND_EXITED;
            ev.id   = slot_id[i];
            ev.last = 1'b0;
            pending_events.insert(pending_events.size(), ev);
            slot_used[i] = 1'b0;
          end
          slot_seen[i] = 1'b0;
        end
      end
      if (pending_events.size() > first)
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    function void check_event(logic [1:0] kind, logic [31:0] id, logic last);
      tracker_event_t ev;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind=%0d id=%h last=%0b", $time, kind, id, last);
        mismatches++;
        return;
      end
      ev = pending_events.pop_front();
      if (kind !== ev.kind) begin
        $display("%0t: event_kind expected %0d actual %0d", $time, ev.kind, kind);
        mismatches++;
      end
      if (id !== ev.id) begin
        $display("%0t: event_id expected %h actual %h", $time, ev.id, id);
        mismatches++;
      end
      if (last !== ev.last) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, ev.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode_i = MODE_PRESENT;
  logic [31:0] shape_id_i = '0;
  logic        event_valid_o;
  logic [1:0]  event_kind_o;
  logic [31:0] event_id_o;
  logic        last_of_run_o;

  membership_board board = new();
  int unsigned     idle_pct = 0;
  int unsigned     beats_sent = 0;
  int unsigned     stall_cycles = 0;
  logic [31:0]     id_pool [POOL_SIZE];

  overlap_set_enter_exit_tracker_top #(
    .SET_DEPTH(SET_DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .shape_id_i   (shape_id_i),
    .event_valid_o(event_valid_o),
    .event_kind_o (event_kind_o),
    .event_id_o   (event_id_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample beats and events at each edge; end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (event_valid_o) board.check_event(event_kind_o, event_id_o, last_of_run_o);
      if (start && !busy) board.note_beat(mode_i, shape_id_i);
      if (event_valid_o || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Hold start low for random gaps, then present one beat until it is taken
  task automatic send_beat(input logic mode, input logic [31:0] id);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    mode_i     <= mode;
    shape_id_i <= id;
    do @(posedge clk_i); while (busy);
    beats_sent++;
  endtask

  // Run frames of IDs drawn mostly from a pool larger than the set, plus some stray empty frames
  task automatic random_frames(input int unsigned quota);
    int unsigned target;
    int unsigned len;
    logic [31:0] id;
    target = beats_sent + quota;
    while (beats_sent < target) begin
      len = $urandom_range(0, 18);
      repeat (len) begin
        if ($urandom_range(99) < 80) id = id_pool[$urandom_range(POOL_SIZE - 1)];
        else id = $urandom();
        send_beat(MODE_PRESENT, id);
      end
      send_beat(MODE_FRAME_END, $urandom());
      if ($urandom_range(99) < 15) send_beat(MODE_FRAME_END, $urandom());
    end
  endtask

  initial begin
    foreach (id_pool[i]) id_pool[i] = $urandom();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Frame with a duplicate; nothing to remove at its end
    send_beat(MODE_PRESENT, 32'h0000_0000);
    send_beat(MODE_PRESENT, 32'hFFFF_FFFF);
    send_beat(MODE_PRESENT, 32'h0000_0000);
    send_beat(MODE_FRAME_END, 32'hFFFF_FFFF);
    // One member drops out
    send_beat(MODE_PRESENT, 32'h0000_0000);
    send_beat(MODE_FRAME_END, 32'h0000_0000);
    // Fill the set, overflow twice with the same ID
    send_beat(MODE_PRESENT, 32'h0000_0000);
    for (int k = 1; k < SET_DEPTH; k++) send_beat(MODE_PRESENT, 32'h5A00_0000 | k);
    send_beat(MODE_PRESENT, 32'hC3C3_3C3C);
    send_beat(MODE_PRESENT, 32'hC3C3_3C3C);
    send_beat(MODE_FRAME_END, 32'h0);
    // Empty frame: every member exits
    send_beat(MODE_FRAME_END, 32'h0);

    // Random frames under three sender idle rates
    idle_pct = 0;
    random_frames(25);
    idle_pct = 61;
    random_frames(25);
    idle_pct = 34;
    random_frames(25);

    start <= 1'b0;
    while (board.pending_events.size() != 0) @(posedge clk_i);
    repeat (2 * SET_DEPTH) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== overlap_set_enter_exit_tracker_top.f =====
sv/otset_pkg.sv
sv/otset_cell.sv
sv/overlap_set_enter_exit_tracker_top.sv
sv/otset_checker.sv
sim/tb.sv
